[hw/rtl/isbrs_pkg.sv]
// Shared types, constants and step tables for the sensor burst-read sequencer.
package isbrs_pkg;

  localparam int unsigned StepW   = 6;
  localparam int unsigned SlotW   = 5;
  localparam logic [StepW-1:0] LastStep = 6'd44;
  localparam logic [StepW-1:0] DoneStep = 6'd45;
  localparam logic [StepW-1:0] LongGapStep = 6'd31;

  localparam logic [7:0] ReadFill = 8'hFF;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_WRITE   = 3'd2,
    ACT_RD_ACK  = 3'd3,
    ACT_RD_NACK = 3'd4,
    ACT_STOP    = 3'd5,
    ACT_RESTART = 3'd6
  } bus_action_e;

  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_EVENT = 1'b1
  } command_e;

  // Item held between the front end and the lookup stage.
  typedef struct packed {
    command_e         cmd;
    logic [7:0]       rx;
    logic [StepW-1:0] step;
    logic             en;
  } item_t;

  typedef struct packed {
    logic [StepW-1:0] step;
    bus_action_e      action;
    logic [7:0]       tx;
    logic             long_gap;
    logic             cap_valid;
    logic [SlotW-1:0] cap_index;
    logic [7:0]       cap_byte;
    logic             done;
  } result_t;

  function automatic bus_action_e step_action(input logic [StepW-1:0] s);
    bus_action_e a;
    a = ACT_NONE;
    case (s)
      6'd0, 6'd3, 6'd22, 6'd34:                           a = ACT_START;
      6'd1, 6'd2, 6'd4, 6'd20, 6'd21, 6'd23,
      6'd32, 6'd33, 6'd35:                                a = ACT_WRITE;
      6'd18, 6'd30, 6'd43:                                a = ACT_RD_NACK;
      6'd19, 6'd31:                                       a = ACT_RESTART;
      6'd44:                                              a = ACT_STOP;
      default: begin
        if ((s >= 6'd5 && s <= 6'd17) || (s >= 6'd24 && s <= 6'd29) ||
            (s >= 6'd36 && s <= 6'd42)) begin
          a = ACT_RD_ACK;
        end
      end
    endcase
    return a;
  endfunction

  // Address (shifted, low bit selects read) or register byte of write steps.
  function automatic logic [7:0] step_tx(input logic [StepW-1:0] s);
    logic [7:0] b;
    case (s)
      6'd1:    b = 8'h68 << 1;
      6'd2:    b = 8'd59;
      6'd4:    b = (8'h68 << 1) | 8'h01;
      6'd20:   b = 8'h0C << 1;
      6'd21:   b = 8'h03;
      6'd23:   b = (8'h0C << 1) | 8'h01;
      6'd32:   b = 8'h76 << 1;
      6'd33:   b = 8'hF7;
      6'd35:   b = (8'h76 << 1) | 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Capture slot of a step; the second device's data bytes are pair-swapped
  // and its status byte is dropped.
  function automatic logic [SlotW:0] step_slot(input logic [StepW-1:0] s);
    logic [SlotW:0] r;
    r = '0;
    case (s)
      6'd25:   r = {1'b1, 5'd15};
      6'd26:   r = {1'b1, 5'd14};
      6'd27:   r = {1'b1, 5'd17};
      6'd28:   r = {1'b1, 5'd16};
      6'd29:   r = {1'b1, 5'd19};
      6'd30:   r = {1'b1, 5'd18};
      default: begin
        if (s >= 6'd6 && s <= 6'd19) begin
          r = {1'b1, SlotW'(s - 6'd6)};
        end else if (s >= 6'd37 && s <= 6'd44) begin
          r = {1'b1, SlotW'(s - 6'd17)};
        end
      end
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/isbrs_front.sv]
// Input register stage: step counter, enable register and captured item.
module isbrs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                advance_i,
  output logic                item_valid_o,
  output isbrs_pkg::item_t    item_o
);
  import isbrs_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  logic             en_q;
  logic             valid_q;
  item_t            item_q, item_d;
  logic             accept;

  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    step_d = step_q;
    if (command_e'(command_i) == CMD_BEGIN) begin
      step_d = '0;
    end else if (step_q < DoneStep) begin
      step_d = step_q + 1'b1;
    end
    item_d.cmd  = command_e'(command_i);
    item_d.rx   = rx_byte_i;
    item_d.step = step_d;
    item_d.en   = en_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      en_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (accept) begin
        step_q  <= step_d;
        valid_q <= 1'b1;
      end else if (advance_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[hw/rtl/isbrs_lookup.sv]
// Step decode: bus action, transmit byte and capture slot of one item.
module isbrs_lookup (
  input  isbrs_pkg::item_t   item_i,
  output isbrs_pkg::result_t result_o
);
  import isbrs_pkg::*;

  bus_action_e      act;
  logic [SlotW:0]   slot;
  logic             live;

  assign act  = step_action(item_i.step);
  assign slot = step_slot(item_i.step);
  assign live = item_i.en && (item_i.step <= LastStep);

  always_comb begin
    result_o           = '0;
    result_o.step      = item_i.step;
    result_o.action    = ACT_NONE;
    if (item_i.cmd == CMD_BEGIN) begin
      result_o.action = ACT_START;
    end else if (live) begin
      result_o.action = act;
      if (act == ACT_WRITE) begin
        result_o.tx = step_tx(item_i.step);
      end else if (act == ACT_RD_ACK || act == ACT_RD_NACK) begin
        result_o.tx = ReadFill;
      end
      result_o.long_gap  = (act == ACT_RESTART) && (item_i.step == LongGapStep);
      result_o.cap_valid = slot[SlotW];
      if (slot[SlotW]) begin
        result_o.cap_index = slot[SlotW-1:0];
        result_o.cap_byte  = item_i.rx;
      end
      result_o.done = (item_i.step == LastStep);
    end
  end

endmodule

[hw/rtl/i2c_sensor_burst_read_sequencer.sv]
// Top level of the three-sensor burst-read bus sequencer.
//
// Usage:
//   Each input transaction carries a command (begin a read cycle, or a bus
//   operation completed) and the byte found in the bus data register. Every
//   input transaction yields exactly one result transaction: the new step,
//   the bus action to issue with its transmit byte and gap flag, an optional
//   capture slot for the received byte, and a cycle-done flag on the final
//   stop.
//   The input register, where the step counter updates, and the result
//   register after the table decode lie between input acceptance and output
//   valid. Throughput is one transaction per cycle while the receiver is
//   ready; the step counter update is the only loop.
//   A stalled receiver holds the result register; the input register still
//   takes one more transaction, then in_ready_o drops until the output drains.
//   Reset clears the step to 0, cycle_enable to 0 and empties both stages.
//   Write cycle_enable through cfg_we_i/cfg_wdata_i only while idle.
module i2c_sensor_burst_read_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] step_o,
  output logic [2:0] bus_action_o,
  output logic [7:0] tx_byte_o,
  output logic       long_gap_o,
  output logic       capture_valid_o,
  output logic [4:0] capture_index_o,
  output logic [7:0] capture_byte_o,
  output logic       cycle_done_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);
  import isbrs_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    out_free;
  logic    advance;
  result_t res_d, res_q;
  logic    out_valid_q;

  // Output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = item_valid && out_free;

  isbrs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .rx_byte_i    (rx_byte_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  isbrs_lookup u_lookup (
    .item_i   (item),
    .result_o (res_d)
  );

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= item_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_o          = res_q.step;
  assign bus_action_o    = res_q.action;
  assign tx_byte_o       = res_q.tx;
  assign long_gap_o      = res_q.long_gap;
  assign capture_valid_o = res_q.cap_valid;
  assign capture_index_o = res_q.cap_index;
  assign capture_byte_o  = res_q.cap_byte;
  assign cycle_done_o    = res_q.done;

endmodule

[hw/rtl/isbrs_checker.sv]
// Port-level checks for the burst-read sequencer, bound to the top level.
module isbrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [5:0] step_o,
  input logic [2:0] bus_action_o,
  input logic [7:0] tx_byte_o,
  input logic       long_gap_o,
  input logic       capture_valid_o,
  input logic [4:0] capture_index_o,
  input logic       cycle_done_o
);
  import isbrs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(step_o))
    else $error("result dropped or changed while stalled");

  // The byte that completes a read lands with the next step's action, which
  // can be a read, stop then start, or the final stop, never a write or start.
  a_capture_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && capture_valid_o |->
      bus_action_o != ACT_NONE && bus_action_o != ACT_START &&
      bus_action_o != ACT_WRITE && capture_index_o <= 5'd27)
    else $error("capture on a step that moves no data");

  a_done_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cycle_done_o |-> step_o == LastStep && bus_action_o == ACT_STOP)
    else $error("cycle done away from the final stop");

  a_gap_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && long_gap_o |-> bus_action_o == ACT_RESTART && step_o == LongGapStep)
    else $error("long gap without stop then start");

  a_tx_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (bus_action_o == ACT_RD_ACK || bus_action_o == ACT_RD_NACK) |->
      tx_byte_o == ReadFill)
    else $error("read step without the fill byte");

endmodule

bind i2c_sensor_burst_read_sequencer isbrs_checker u_isbrs_checker (.*);

[sim/tb.sv]
// Self-checking testbench for the three-sensor burst-read bus sequencer.
module tb;
  import isbrs_pkg::*;

  // Device addresses (7 bit) and first registers of the three burst reads.
  localparam logic [6:0] DevA = 7'h68;
  localparam logic [6:0] DevB = 7'h0C;
  localparam logic [6:0] DevC = 7'h76;
  localparam logic [7:0] RegA = 8'd59;
  localparam logic [7:0] RegB = 8'h03;
  localparam logic [7:0] RegC = 8'hF7;

  // One letter per step, step 0 first: S start, W write, A read with ack,
  // N read without ack, R stop then start, P final stop.
  localparam logic [45*8-1:0] ActMap =
    {"SWWSW", "AAAAAAAAAAAAA", "NRWWSW", "AAAAAA", "NRWWSW", "AAAAAAA", "NP"};

  localparam int RandomItems = 1750;
  localparam int QuietAfter  = 1500;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  command_e   cmd_drv;
  logic [7:0] rx_drv;
  logic       out_valid;
  logic       out_ready;
  logic [5:0] step_out;
  logic [2:0] action_out;
  logic [7:0] tx_out;
  logic       gap_out;
  logic       cap_valid_out;
  logic [4:0] cap_index_out;
  logic [7:0] cap_byte_out;
  logic       done_out;
  logic       cfg_we;
  logic       cfg_wdata;

  // Predictor state: mirrors the step counter and the enable register.
  logic [5:0] seq_step;
  logic       seq_enable;

  result_t    bus_steps_due[$];
  int         mismatches;
  int         items_sent;
  bit         quiet;
  bit         long_backpressure;

  typedef struct {
    logic     en;
    command_e cmd;
    logic [7:0] rx;
    int       reps;
    bit       typed;
    result_t  fixed;
  } plan_row_t;

  plan_row_t plan[$];

  i2c_sensor_burst_read_sequencer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (cmd_drv),
    .rx_byte_i      (rx_drv),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .step_o         (step_out),
    .bus_action_o   (action_out),
    .tx_byte_o      (tx_out),
    .long_gap_o     (gap_out),
    .capture_valid_o(cap_valid_out),
    .capture_index_o(cap_index_out),
    .capture_byte_o (cap_byte_out),
    .cycle_done_o   (done_out),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Decode the step letter map into a bus action.
  function automatic bus_action_e action_of(logic [5:0] s);
    logic [7:0] c;
    c = ActMap[(44 - s) * 8 +: 8];
    case (c)
      "S":     return ACT_START;
      "W":     return ACT_WRITE;
      "A":     return ACT_RD_ACK;
      "N":     return ACT_RD_NACK;
      "R":     return ACT_RESTART;
      "P":     return ACT_STOP;
      default: return ACT_NONE;
    endcase
  endfunction

  // Each burst writes the device address, the register, then the address
  // again with the read bit set after the repeated start.
  function automatic logic [7:0] write_byte_of(logic [5:0] s);
    case (s)
      6'd1:    return {DevA, 1'b0};
      6'd2:    return RegA;
      6'd4:    return {DevA, 1'b1};
      6'd20:   return {DevB, 1'b0};
      6'd21:   return RegB;
      6'd23:   return {DevB, 1'b1};
      6'd32:   return {DevC, 1'b0};
      6'd33:   return RegC;
      6'd35:   return {DevC, 1'b1};
      default: return 8'h00;
    endcase
  endfunction

  // Capture slot of the byte completed at step s, or -1 when none is kept.
  // The middle device's bytes land pair-swapped; its status byte is dropped.
  function automatic int slot_of(logic [5:0] s);
    if (s >= 6 && s <= 19) return int'(s) - 6;
    if (s >= 25 && s <= 30) return 14 + ((int'(s) - 25) ^ 1);
    if (s >= 37 && s <= 44) return int'(s) - 17;
    return -1;
  endfunction

  // Advance the mirrored sequencer by one transaction and return its output.
  function automatic result_t advance_sequence(command_e cmd, logic [7:0] rx);
    result_t r;
    int      slot;
    r = '0;
    if (cmd == CMD_BEGIN) begin
      seq_step = '0;
      r.action = ACT_START;
    end else begin
      if (seq_step < DoneStep) seq_step = seq_step + 6'd1;
      if (seq_enable && seq_step <= LastStep) begin
        r.action = action_of(seq_step);
        if (r.action == ACT_WRITE) begin
          r.tx = write_byte_of(seq_step);
        end else if (r.action == ACT_RD_ACK || r.action == ACT_RD_NACK) begin
          r.tx = ReadFill;
        end
        r.long_gap = (r.action == ACT_RESTART) && (seq_step == LongGapStep);
        slot = slot_of(seq_step);
        if (slot >= 0) begin
          r.cap_valid = 1'b1;
          r.cap_index = slot[4:0];
          r.cap_byte  = rx;
        end
        r.done = (seq_step == LastStep);
      end
    end
    r.step = seq_step;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------

  task automatic flag(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Offer one transaction, hold it until taken, then queue its expectation.
  // A typed row queues the hand-written result but still advances the mirror.
  task automatic send_item(command_e cmd, logic [7:0] rx, bit typed, result_t fixed);
    int      gap;
    result_t pred;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cmd_drv  <= cmd;
    rx_drv   <= rx;
    do @(posedge clk); while (!in_ready);
    pred = advance_sequence(cmd, rx);
    bus_steps_due.push_back(typed ? fixed : pred);
    items_sent++;
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (bus_steps_due.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    if (bus_steps_due.size() != 0) begin
      flag($sformatf("%0d results never arrived", bus_steps_due.size()));
      bus_steps_due.delete();
    end
    repeat (3) @(posedge clk);
  endtask

  // Write the enable register while the block is idle.
  task automatic set_enable(logic v);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    seq_enable = v;
  endtask

  // One read cycle: begin, then a number of bus-complete events.
  task automatic run_cycle(int events);
    send_item(CMD_BEGIN, 8'($urandom_range(0, 255)), 1'b0, '0);
    repeat (events) send_item(CMD_EVENT, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random ready bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (long_backpressure) begin
        // Hold off long enough for the block to fill and stall its input.
        stall_left        = 40;
        long_backpressure = 1'b0;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bus_steps_due.size() == 0) begin
        flag($sformatf("unexpected result at step %0d", step_out));
      end else begin
        want = bus_steps_due.pop_front();
        if (step_out !== want.step)
          flag($sformatf("step got %0d want %0d", step_out, want.step));
        if (action_out !== want.action)
          flag($sformatf("step %0d action got %0d want %0d", want.step, action_out,
                         want.action));
        if (tx_out !== want.tx)
          flag($sformatf("step %0d tx got %02h want %02h", want.step, tx_out, want.tx));
        if (gap_out !== want.long_gap)
          flag($sformatf("step %0d long_gap got %0b want %0b", want.step, gap_out,
                         want.long_gap));
        if (cap_valid_out !== want.cap_valid)
          flag($sformatf("step %0d capture_valid got %0b want %0b", want.step,
                         cap_valid_out, want.cap_valid));
        if (cap_index_out !== want.cap_index)
          flag($sformatf("step %0d capture_index got %0d want %0d", want.step,
                         cap_index_out, want.cap_index));
        if (cap_byte_out !== want.cap_byte)
          flag($sformatf("step %0d capture_byte got %02h want %02h", want.step,
                         cap_byte_out, want.cap_byte));
        if (done_out !== want.done)
          flag($sformatf("step %0d cycle_done got %0b want %0b", want.step, done_out,
                         want.done));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int kind;
    int phase_no;

    rst_n             = 1'b0;
    in_valid          = 1'b0;
    cmd_drv           = CMD_BEGIN;
    rx_drv            = 8'h00;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    seq_step          = '0;
    seq_enable        = 1'b0;
    mismatches        = 0;
    items_sent        = 0;
    quiet             = 1'b0;
    long_backpressure = 1'b0;
    phase_no          = 0;

    // Directed walk: disabled after reset, one full enabled cycle with its
    // swap, long gap, final stop and saturation, then begin from odd states.
    plan.push_back('{1'b0, CMD_EVENT, 8'hA5, 1, 1'b1,
                     '{6'd1, ACT_NONE, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0}});
    plan.push_back('{1'b0, CMD_BEGIN, 8'hFF, 1, 1'b1,
                     '{6'd0, ACT_START, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0}});
    plan.push_back('{1'b1, CMD_BEGIN, 8'h00, 1, 1'b1,
                     '{6'd0, ACT_START, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0}});
    plan.push_back('{1'b1, CMD_EVENT, 8'h00, 1, 1'b1,
                     '{6'd1, ACT_WRITE, 8'hD0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0}});
    plan.push_back('{1'b1, CMD_EVENT, 8'hFF, 1, 1'b1,
                     '{6'd2, ACT_WRITE, 8'd59, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0}});
    plan.push_back('{1'b1, CMD_EVENT, 8'h3C, 3, 1'b0, '0});
    plan.push_back('{1'b1, CMD_EVENT, 8'hFF, 1, 1'b1,
                     '{6'd6, ACT_RD_ACK, 8'hFF, 1'b0, 1'b1, 5'd0, 8'hFF, 1'b0}});
    plan.push_back('{1'b1, CMD_EVENT, 8'h00, 13, 1'b0, '0});
    plan.push_back('{1'b1, CMD_EVENT, 8'h81, 11, 1'b0, '0});
    plan.push_back('{1'b1, CMD_EVENT, 8'h00, 1, 1'b1,
                     '{6'd31, ACT_RESTART, 8'h00, 1'b1, 1'b0, 5'd0, 8'h00, 1'b0}});
    plan.push_back('{1'b1, CMD_EVENT, 8'h5A, 12, 1'b0, '0});
    plan.push_back('{1'b1, CMD_EVENT, 8'hFF, 1, 1'b1,
                     '{6'd44, ACT_STOP, 8'h00, 1'b0, 1'b1, 5'd27, 8'hFF, 1'b1}});
    plan.push_back('{1'b1, CMD_EVENT, 8'h77, 2, 1'b1,
                     '{6'd45, ACT_NONE, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0}});
    plan.push_back('{1'b0, CMD_BEGIN, 8'h00, 1, 1'b1,
                     '{6'd0, ACT_START, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0}});
    plan.push_back('{1'b0, CMD_EVENT, 8'hC3, 3, 1'b0, '0});
    plan.push_back('{1'b1, CMD_BEGIN, 8'h55, 1, 1'b1,
                     '{6'd0, ACT_START, 8'h00, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0}});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].en != seq_enable) set_enable(plan[i].en);
      repeat (plan[i].reps) send_item(plan[i].cmd, plan[i].rx, plan[i].typed, plan[i].fixed);
    end

    // Random phases: mostly complete cycles with random bytes, some noise,
    // some cut-short cycles, and backpressure phases. Rewrite the enable
    // register between phases.
    items_sent = 0;
    while (items_sent < RandomItems) begin
      phase_no++;
      quiet = (items_sent >= QuietAfter);
      set_enable($urandom_range(0, 3) != 0);
      kind = (phase_no == 1) ? 9 : $urandom_range(0, 9);
      case (kind)
        7: begin
          // Noise: mostly events, an occasional begin anywhere.
          repeat ($urandom_range(10, 40)) begin
            send_item(($urandom_range(0, 9) == 0) ? CMD_BEGIN : CMD_EVENT,
                      8'($urandom_range(0, 255)), 1'b0, '0);
          end
        end
        8: begin
          // Broken cycles: restart before the final stop.
          repeat ($urandom_range(1, 3)) run_cycle($urandom_range(0, 43));
        end
        9: begin
          // Stall the receiver while the sender keeps offering, then pause
          // the sender until everything has drained.
          long_backpressure = !quiet;
          run_cycle(44);
          wait_drained();
          run_cycle(45);
        end
        default: begin
          repeat ($urandom_range(1, 3)) begin
            run_cycle(($urandom_range(0, 3) == 0) ? $urandom_range(45, 47) : 44);
          end
        end
      endcase
    end

    quiet = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
